// ----- design/qmn_pkg.sv -----
// shared types, widths and helpers for the quaternion multiply-normalize block
// no dependencies; used by every design file
package qmn_pkg;

  localparam int CW     = 16;                               // component width
  localparam int FB     = 14;                               // fraction bits
  localparam int PSHIFT = (2 * CW > 62) ? (2 * CW - 62) : 0;
  localparam int PRW    = 2 * CW - PSHIFT;                  // partial product width
  localparam int PW     = PRW + 2;                          // product component width
  localparam int MW     = PW - 1;                           // product magnitude width
  localparam int NW     = 31;                               // normalized magnitude width
  localparam int XW     = (MW > NW) ? MW : NW;              // shifter width
  localparam int SHW    = $clog2(XW);                       // shift amount width
  localparam int SW     = 2 * NW + 2;                       // sum of squares width
  localparam int LW     = SW / 2;                           // root width
  localparam int QW     = FB + 1;                           // quotient width
  localparam int DVW    = LW + QW;                          // divider remainder width
  localparam int QD     = 4;                                // queue depth
  localparam int QAW    = $clog2(QD);

  typedef struct packed {
    logic signed [CW-1:0] a_w;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_w;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] r_w;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;
    logic                 zero_norm;
  } out_t;

  // normalized product handed from front to back
  typedef struct packed {
    logic [3:0][NW-1:0] m;
    logic [3:0]         neg;
    logic               zero;
  } norm_t;

  // signed product, magnitude truncated toward zero by PSHIFT bits
  function automatic logic signed [PRW-1:0] pmul(logic signed [CW-1:0] x,
                                                 logic signed [CW-1:0] y);
    logic signed [2*CW-1:0] full;
    logic [2*CW-1:0]        mag;
    logic [PRW-1:0]         t;
    full = x * y;
    mag  = full[2*CW-1] ? (2*CW)'(-full) : (2*CW)'(full);
    mag  = mag >> PSHIFT;
    t    = mag[PRW-1:0];
    return full[2*CW-1] ? $signed(-t) : $signed(t);
  endfunction

endpackage

// ----- design/qmn_front.sv -----
// front part: hamilton product, magnitudes and leading-one normalization
// depends on qmn_pkg
module qmn_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  qmn_pkg::in_t          in_data,
  output logic                  f_valid,
  input  logic                  f_full,
  output qmn_pkg::norm_t        f_data
);

  logic [4:0] vld_r;
  logic       en;

  logic signed [qmn_pkg::CW-1:0]  av [4];
  logic signed [qmn_pkg::CW-1:0]  bv [4];
  logic signed [qmn_pkg::PRW-1:0] pr_r [4][4];
  logic signed [qmn_pkg::PW-1:0]  p [4];
  logic [qmn_pkg::PW-1:0]         pabs [4];
  logic [qmn_pkg::MW-1:0]         mag2_r [4];
  logic [3:0]                     neg2_r;
  logic [qmn_pkg::MW-1:0]         b01, b23, big;
  logic [qmn_pkg::MW-1:0]         big_r;
  logic [qmn_pkg::MW-1:0]         mag3_r [4];
  logic [3:0]                     neg3_r;
  logic [qmn_pkg::SHW-1:0]        lead;
  logic [qmn_pkg::SHW-1:0]        lead_r;
  logic [qmn_pkg::MW-1:0]         mag4_r [4];
  logic [3:0]                     neg4_r;
  logic                           zero4_r;
  logic [qmn_pkg::XW-1:0]         shv [4];
  qmn_pkg::norm_t                 nrm;
  qmn_pkg::norm_t                 out_r;

  assign en       = !(vld_r[4] && f_full);
  assign in_stall = !en;
  assign f_valid  = vld_r[4];
  assign f_data   = out_r;

  assign av[0] = in_data.a_w;
  assign av[1] = in_data.a_x;
  assign av[2] = in_data.a_y;
  assign av[3] = in_data.a_z;
  assign bv[0] = in_data.b_w;
  assign bv[1] = in_data.b_x;
  assign bv[2] = in_data.b_y;
  assign bv[3] = in_data.b_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  // stage 1: sixteen partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pr_r[i][j] <= qmn_pkg::pmul(av[i], bv[j]);
        end
      end
    end
  end

  // stage 2: product components, sign and magnitude
  always_comb begin
    p[0] = qmn_pkg::PW'(pr_r[0][0]) - qmn_pkg::PW'(pr_r[1][1])
         - qmn_pkg::PW'(pr_r[2][2]) - qmn_pkg::PW'(pr_r[3][3]);
    p[1] = qmn_pkg::PW'(pr_r[0][1]) + qmn_pkg::PW'(pr_r[1][0])
         + qmn_pkg::PW'(pr_r[2][3]) - qmn_pkg::PW'(pr_r[3][2]);
    p[2] = qmn_pkg::PW'(pr_r[0][2]) - qmn_pkg::PW'(pr_r[1][3])
         + qmn_pkg::PW'(pr_r[2][0]) + qmn_pkg::PW'(pr_r[3][1]);
    p[3] = qmn_pkg::PW'(pr_r[0][3]) + qmn_pkg::PW'(pr_r[1][2])
         - qmn_pkg::PW'(pr_r[2][1]) + qmn_pkg::PW'(pr_r[3][0]);
    for (int i = 0; i < 4; i++) begin
      pabs[i] = p[i][qmn_pkg::PW-1] ? qmn_pkg::PW'(-p[i]) : qmn_pkg::PW'(p[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        mag2_r[i] <= pabs[i][qmn_pkg::MW-1:0];
        neg2_r[i] <= p[i][qmn_pkg::PW-1];
      end
    end
  end

  // stage 3: largest magnitude
  assign b01 = (mag2_r[0] > mag2_r[1]) ? mag2_r[0] : mag2_r[1];
  assign b23 = (mag2_r[2] > mag2_r[3]) ? mag2_r[2] : mag2_r[3];
  assign big = (b01 > b23) ? b01 : b23;

  always_ff @(posedge clk) begin
    if (en) begin
      big_r  <= big;
      mag3_r <= mag2_r;
      neg3_r <= neg2_r;
    end
  end

  // stage 4: leading-one position
  always_comb begin
    lead = '0;
    for (int i = 0; i < qmn_pkg::MW; i++) begin
      if (big_r[i]) lead = qmn_pkg::SHW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lead_r  <= lead;
      mag4_r  <= mag3_r;
      neg4_r  <= neg3_r;
      zero4_r <= (big_r == '0);
    end
  end

  // stage 5: place the leading one of the largest at bit NW-1
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (lead_r >= qmn_pkg::SHW'(qmn_pkg::NW - 1)) begin
        shv[i] = qmn_pkg::XW'(mag4_r[i]) >> (lead_r - qmn_pkg::SHW'(qmn_pkg::NW - 1));
      end else begin
        shv[i] = qmn_pkg::XW'(mag4_r[i]) << (qmn_pkg::SHW'(qmn_pkg::NW - 1) - lead_r);
      end
      nrm.m[i] = shv[i][qmn_pkg::NW-1:0];
    end
    nrm.neg  = neg4_r;
    nrm.zero = zero4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= nrm;
    end
  end

endmodule

// ----- design/qmn_fifo.sv -----
// short queue between front and back parts
// depends on qmn_pkg
module qmn_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  qmn_pkg::norm_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output qmn_pkg::norm_t head
);

  qmn_pkg::norm_t           mem_r [qmn_pkg::QD];
  logic [qmn_pkg::QAW-1:0]  wr_r, rd_r;
  logic [qmn_pkg::QAW:0]    cnt_r;

  assign full  = (cnt_r == (qmn_pkg::QAW+1)'(qmn_pkg::QD));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

// ----- design/qmn_back.sv -----
// back part: sum of squares, pipelined square root and dividers, output register
// depends on qmn_pkg
module qmn_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  qmn_pkg::norm_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output qmn_pkg::out_t  out_data
);

  localparam int LW  = qmn_pkg::LW;
  localparam int QW  = qmn_pkg::QW;
  localparam int SW  = qmn_pkg::SW;
  localparam int DVW = qmn_pkg::DVW;
  localparam int NW  = qmn_pkg::NW;

  logic en;

  logic                 v_sq_r;
  logic [2*NW-1:0]      sq_r [4];
  qmn_pkg::norm_t       bk_sq_r;

  logic                 v_sum_r;
  logic [SW-1:0]        sum_r;
  qmn_pkg::norm_t       bk_sum_r;

  logic [LW-1:0]        v_rt_r;
  logic [SW-1:0]        rem_rt_r  [LW];
  logic [LW-1:0]        root_rt_r [LW];
  qmn_pkg::norm_t       bk_rt_r   [LW];

  logic                 v_pp_r;
  logic [DVW-1:0]       num_pp_r [4];
  logic [LW-1:0]        len_pp_r;
  qmn_pkg::norm_t       bk_pp_r;

  logic [QW-1:0]        v_dv_r;
  logic [DVW-1:0]       rem_dv_r [QW][4];
  logic [QW-1:0]        q_dv_r   [QW][4];
  logic [LW-1:0]        len_dv_r [QW];
  qmn_pkg::norm_t       bk_dv_r  [QW];

  logic                 out_valid_r;
  qmn_pkg::out_t        out_r;
  logic [qmn_pkg::CW-1:0] res [4];

  assign en        = !(out_valid_r && out_stall);
  assign q_pop     = en && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_sq_r      <= 1'b0;
      v_sum_r     <= 1'b0;
      v_rt_r      <= '0;
      v_pp_r      <= 1'b0;
      v_dv_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_sq_r      <= !q_empty;
      v_sum_r     <= v_sq_r;
      v_rt_r      <= {v_rt_r[LW-2:0], v_sum_r};
      v_pp_r      <= v_rt_r[LW-1];
      v_dv_r      <= {v_dv_r[QW-2:0], v_pp_r};
      out_valid_r <= v_dv_r[QW-1];
    end
  end

  // squares and their sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq_r[i] <= q_head.m[i] * q_head.m[i];
      end
      bk_sq_r  <= q_head;
      sum_r    <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]) + SW'(sq_r[3]);
      bk_sum_r <= bk_sq_r;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < LW; k++) begin : g_rt
    localparam int J = LW - 1 - k;
    logic [SW-1:0] rem_in;
    logic [LW-1:0] root_in;
    logic [SW:0]   trial;
    qmn_pkg::norm_t bk_in;

    if (k == 0) begin : g_first
      assign rem_in  = sum_r;
      assign root_in = '0;
      assign bk_in   = bk_sum_r;
    end else begin : g_next
      assign rem_in  = rem_rt_r[k-1];
      assign root_in = root_rt_r[k-1];
      assign bk_in   = bk_rt_r[k-1];
    end

    assign trial = ((SW+1)'(root_in) << (J + 1)) | ((SW+1)'(1) << (2 * J));

    always_ff @(posedge clk) begin
      if (en) begin
        bk_rt_r[k] <= bk_in;
        if ((SW+1)'(rem_in) >= trial) begin
          rem_rt_r[k]  <= rem_in - trial[SW-1:0];
          root_rt_r[k] <= root_in | (LW'(1) << J);
        end else begin
          rem_rt_r[k]  <= rem_in;
          root_rt_r[k] <= root_in;
        end
      end
    end
  end

  // dividend with half the divisor added for rounding
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        num_pp_r[i] <= (DVW'(bk_rt_r[LW-1].m[i]) << qmn_pkg::FB)
                     + DVW'(root_rt_r[LW-1] >> 1);
      end
      len_pp_r <= root_rt_r[LW-1];
      bk_pp_r  <= bk_rt_r[LW-1];
    end
  end

  // four restoring dividers, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_dv
    localparam int J = QW - 1 - k;
    logic [DVW-1:0] rem_in [4];
    logic [QW-1:0]  q_in   [4];
    logic [LW-1:0]  len_in;
    logic [DVW-1:0] dsh;
    qmn_pkg::norm_t bk_in;

    if (k == 0) begin : g_first
      assign rem_in = num_pp_r;
      assign q_in   = '{default: '0};
      assign len_in = len_pp_r;
      assign bk_in  = bk_pp_r;
    end else begin : g_next
      assign rem_in = rem_dv_r[k-1];
      assign q_in   = q_dv_r[k-1];
      assign len_in = len_dv_r[k-1];
      assign bk_in  = bk_dv_r[k-1];
    end

    assign dsh = DVW'(len_in) << J;

    always_ff @(posedge clk) begin
      if (en) begin
        len_dv_r[k] <= len_in;
        bk_dv_r[k]  <= bk_in;
        for (int i = 0; i < 4; i++) begin
          if (rem_in[i] >= dsh) begin
            rem_dv_r[k][i] <= rem_in[i] - dsh;
            q_dv_r[k][i]   <= q_in[i] | (QW'(1) << J);
          end else begin
            rem_dv_r[k][i] <= rem_in[i];
            q_dv_r[k][i]   <= q_in[i];
          end
        end
      end
    end
  end

  // sign, zero-length override, output register
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      res[i] = qmn_pkg::CW'(q_dv_r[QW-1][i]);
      if (bk_dv_r[QW-1].neg[i]) res[i] = -res[i];
      if (bk_dv_r[QW-1].zero)   res[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.r_w       <= $signed(res[0]);
      out_r.r_x       <= $signed(res[1]);
      out_r.r_y       <= $signed(res[2]);
      out_r.r_z       <= $signed(res[3]);
      out_r.zero_norm <= bk_dv_r[QW-1].zero;
    end
  end

endmodule

// ----- design/quaternion_multiply_normalize.sv -----
// top level of the quaternion multiply-normalize block
// depends on qmn_pkg, qmn_front, qmn_fifo, qmn_back
//
// usage
//   input channel: in_valid / in_stall / in_data carries quaternions a and b
//   in signed Q2.14; a transfer happens when in_valid is high and in_stall low
//   result channel: out_valid / out_stall / out_data carries the normalized
//   hamilton product a*b in Q2.14 plus zero_norm, one result per input
//   throughput: one item per cycle while out_stall is low, set by the fully
//   pipelined square root (one root bit per stage) and the four dividers
//   (one quotient bit per stage)
//   zero-length product gives all-zero components with zero_norm high
//   reset (rst_n low, synchronous) empties every stage and the queue
//   a stalled result holds in the output register; the back pipeline freezes,
//   the front keeps taking items until the four-entry queue is full and an
//   item waits in the front's last stage, then in_stall rises
module quaternion_multiply_normalize (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  qmn_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output qmn_pkg::out_t out_data
);

  // front to queue
  logic           f_valid;
  logic           q_full;
  qmn_pkg::norm_t f_data;
  // queue to back
  logic           q_empty;
  logic           q_pop;
  qmn_pkg::norm_t q_head;

  qmn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .f_valid  (f_valid),
    .f_full   (q_full),
    .f_data   (f_data)
  );

  // push whenever the front's last stage holds an item and there is room
  qmn_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid && !q_full),
    .push_data (f_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  qmn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- design/qmn_checker.sv -----
// port-level checks for the quaternion multiply-normalize block
// depends on qmn_pkg; bound to quaternion_multiply_normalize
module qmn_port_checks (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_stall,
  input qmn_pkg::out_t out_data
);

  // zero length gives zero components
  a_zero_comp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_norm |->
      out_data.r_w == '0 && out_data.r_x == '0 &&
      out_data.r_y == '0 && out_data.r_z == '0)
    else $error("zero_norm with nonzero component");

  // unit length bounds every component
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      int'(out_data.r_w) <= (1 << qmn_pkg::FB) && int'(out_data.r_w) >= -(1 << qmn_pkg::FB) &&
      int'(out_data.r_x) <= (1 << qmn_pkg::FB) && int'(out_data.r_x) >= -(1 << qmn_pkg::FB) &&
      int'(out_data.r_y) <= (1 << qmn_pkg::FB) && int'(out_data.r_y) >= -(1 << qmn_pkg::FB) &&
      int'(out_data.r_z) <= (1 << qmn_pkg::FB) && int'(out_data.r_z) >= -(1 << qmn_pkg::FB))
    else $error("component beyond unit length");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind quaternion_multiply_normalize qmn_port_checks u_qmn_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- verif/qmn_checker.sv -----
// checker for the quaternion multiply-normalize block: watches both channels,
// predicts each normalized product and compares; depends on qmn_pkg
`timescale 1ns / 100ps
module qmn_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  qmn_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  qmn_pkg::out_t out_data,
  output int            fail_count,
  output int            pending_count
);

  qmn_pkg::out_t product_queue[$];

  function automatic longint smul(longint x, longint y);
    longint pr;
    longint mag;
    pr = x * y;
    mag = (pr < 0) ? -pr : pr;
    mag = mag >>> qmn_pkg::PSHIFT;
    return (pr < 0) ? -mag : mag;
  endfunction

  function automatic longint unsigned int_root(longint unsigned s);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic qmn_pkg::out_t unit_product(qmn_pkg::in_t d);
    longint aw, ax, ay, az, bw, bx, by, bz;
    longint p[4];
    longint unsigned m[4];
    bit neg[4];
    longint unsigned big, s, len, r;
    logic [qmn_pkg::CW-1:0] comp[4];
    qmn_pkg::out_t o;
    aw = d.a_w; ax = d.a_x; ay = d.a_y; az = d.a_z;
    bw = d.b_w; bx = d.b_x; by = d.b_y; bz = d.b_z;
    p[0] = smul(aw, bw) - smul(ax, bx) - smul(ay, by) - smul(az, bz);
    p[1] = smul(aw, bx) + smul(ax, bw) + smul(ay, bz) - smul(az, by);
    p[2] = smul(aw, by) - smul(ax, bz) + smul(ay, bw) + smul(az, bx);
    p[3] = smul(aw, bz) + smul(ax, by) - smul(ay, bx) + smul(az, bw);
    big = 0;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = p[i] < 0;
      m[i] = neg[i] ? -p[i] : p[i];
      if (m[i] > big) big = m[i];
    end
    o = '0;
    if (big == 0) begin
      o.zero_norm = 1'b1;
      return o;
    end
    // bring the largest magnitude into [2^30, 2^31)
    while (big >= (64'd1 << 31)) begin
      big = big >> 1;
      for (int i = 0; i < 4; i++) m[i] = m[i] >> 1;
    end
    while (big < (64'd1 << 30)) begin
      big = big << 1;
      for (int i = 0; i < 4; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < 4; i++) s = s + m[i] * m[i];
    len = int_root(s);
    for (int i = 0; i < 4; i++) begin
      r = ((m[i] << qmn_pkg::FB) + (len >> 1)) / len;
      if (neg[i]) r = -r;
      comp[i] = r[qmn_pkg::CW-1:0];
    end
    o.r_w = comp[0];
    o.r_x = comp[1];
    o.r_y = comp[2];
    o.r_z = comp[3];
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;
  initial pending_count = 0;

  always @(posedge clk) begin
    qmn_pkg::out_t want;
    if (rst_n && in_valid && !in_stall) product_queue.push_back(unit_product(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (product_queue.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        want = product_queue.pop_front();
        if (out_data.r_w !== want.r_w) report("r_w", out_data.r_w, want.r_w);
        if (out_data.r_x !== want.r_x) report("r_x", out_data.r_x, want.r_x);
        if (out_data.r_y !== want.r_y) report("r_y", out_data.r_y, want.r_y);
        if (out_data.r_z !== want.r_z) report("r_z", out_data.r_z, want.r_z);
        if (out_data.zero_norm !== want.zero_norm)
          report("zero_norm", out_data.zero_norm, want.zero_norm);
      end
    end
    pending_count = product_queue.size();
  end
endmodule

// ----- verif/tb_top.sv -----
// testbench top for quaternion_multiply_normalize: drives directed and random
// quaternion pairs with random idling; depends on qmn_pkg, qmn_checker and quaternion_multiply_normalize
`timescale 1ns / 100ps
module tb_top;

  localparam int LATENCY = 56;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 500;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  qmn_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall;
  qmn_pkg::out_t out_data;
  int   fail_count;
  int   pending_count;

  // idle odds in percent for the sender and the receiver
  int   send_idle_pct;
  int   recv_idle_pct;
  int   idle_count;

  qmn_pkg::in_t  directed_items[$];

  quaternion_multiply_normalize i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  qmn_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
    end
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [qmn_pkg::CW-1:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return qmn_pkg::CW'(-$urandom_range(3));
      3: return qmn_pkg::CW'($urandom_range(3));
      default: return qmn_pkg::CW'($urandom);
    endcase
  endfunction

  function automatic qmn_pkg::in_t rand_item();
    qmn_pkg::in_t d;
    d.a_w = rand_comp(); d.a_x = rand_comp(); d.a_y = rand_comp(); d.a_z = rand_comp();
    d.b_w = rand_comp(); d.b_x = rand_comp(); d.b_y = rand_comp(); d.b_z = rand_comp();
    // occasionally zero a whole quaternion so the zero-length case recurs
    if ($urandom_range(30) == 0) {d.a_w, d.a_x, d.a_y, d.a_z} = '0;
    return d;
  endfunction

  // send one item: optional idle cycles, then hold valid until the transfer
  task automatic send_item(qmn_pkg::in_t d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // the extra edge lets the last transfer reach the pending count
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    qmn_pkg::in_t d;
    idle_count    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero length, identity, extremes, pure axes, tiny products
    directed_items.push_back('0);
    directed_items.push_back('{16'h4000, 0, 0, 0, 16'h4000, 0, 0, 0});
    directed_items.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h8000,
                               16'h8000, 16'h8000, 16'h8000, 16'h8000});
    directed_items.push_back('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                               16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    directed_items.push_back('{16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                               16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
    directed_items.push_back('{0, 16'h4000, 0, 0, 0, 0, 16'h4000, 0});
    directed_items.push_back('{0, 0, 16'h4000, 0, 0, 0, 0, 16'h4000});
    directed_items.push_back('{0, 0, 0, 16'hc000, 0, 16'hc000, 0, 0});
    directed_items.push_back('{1, 0, 0, 0, 1, 0, 0, 0});
    directed_items.push_back('{16'hffff, 0, 0, 0, 1, 0, 0, 0});
    directed_items.push_back('{1, 1, 1, 1, 1, 16'hffff, 16'hffff, 16'hffff});
    directed_items.push_back('{16'h4000, 0, 0, 0, 0, 0, 0, 0});
    directed_items.push_back('{16'h2d41, 16'h2d41, 0, 0, 16'h2d41, 0, 16'h2d41, 0});
    directed_items.push_back('{16'h7fff, 1, 0, 0, 16'h8000, 0, 0, 16'hffff});
    foreach (directed_items[i]) send_item(directed_items[i]);
    // hold off until every expected result is back
    drain();

    // random: receiver idles heavily first, then the sender, then neither
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 81 : 0;
      recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 35 : 0;
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        d = rand_item();
        send_item(d);
      end
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
